// ----- rtl/fhm_pkg.sv -----
// Package for the fire heat map spreader: sizes, codes, payload types and helpers.
package fhm_pkg;

    // Largest frame the heat store holds.
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    // Derived widths: store address, frame size (may equal the depth), one dimension.
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int SIZE_W = $clog2(STORE_DEPTH + 1);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);

    // Fixed field and register widths.
    localparam int PIX_W     = 6;
    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 12;
    localparam int SIZE_CFG_W = 7;
    localparam int SEED_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values and the noise generator feedback taps.
    localparam logic [SIZE_CFG_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [SIZE_CFG_W-1:0] HEIGHT_RESET = 7'd64;
    localparam logic [PIX_W-1:0]      BASE_RESET   = 6'd36;
    localparam logic [SEED_W-1:0]     SEED_RESET   = 16'd44257;
    localparam logic [SEED_W-1:0]     LFSR_TAPS    = 16'hB400;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BASE_INTENS  = 2'd2,
        CFG_RANDOM_SEED  = 2'd3
    } t_cfg_index;

    // Command codes carried in the kind field.
    typedef enum logic [KIND_W-1:0] {
        KIND_INIT   = 2'd0,
        KIND_SPREAD = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_SETUP,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_SP_READ,
        S_SP_WRITE,
        S_DONE
    } t_state;

    // Request payloads.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_value;
        logic [KIND_W-1:0] done_kind;
    } t_out_item;

    // Saturate a size register into 2..hi.
    function automatic logic [DIM_W-1:0] clamp_dim(logic [SIZE_CFG_W-1:0] v, int unsigned hi);
        int unsigned vi;
        vi = 32'(v);
        if (vi < 32'd2) begin
            vi = 32'd2;
        end else if (vi > hi) begin
            vi = hi;
        end
        return DIM_W'(vi);
    endfunction

    // One step of the Galois noise generator (right shift).
    function automatic logic [SEED_W-1:0] lfsr_step(logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] n;
        n = s >> 1;
        if (s[0]) begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage

// ----- rtl/fhm_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module fhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/fire_heat_map_spreader_top.sv -----
// Top level of the fire heat map spreader: command sequencer, noise generator and heat store.
// The block keeps a frame of 6-bit heat values in a simple dual-port RAM and takes one
// request at a time; o_in_stall is high while a request is in progress. After reset a clearing
// pass writes zero to all STORE_DEPTH (4096) entries, one per cycle, before the first request
// is taken; configuration writes are accepted during it. Initialize passes a setup state, then
// writes one RAM entry per cycle over the whole store, clearing it and filling the bottom row
// of the frame with the base value on the way; spread reads each pixel of rows 1 to height - 1
// and writes at most one value per pixel through the shared address unit; read issues the RAM
// read, waits for the registered data and returns it (zero outside the frame, with no wait).
// Kind 3 is accepted and dropped in the setup state without a result. A finished result waits
// in the output register while the next request is accepted.
module fire_heat_map_spreader_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  fhm_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output fhm_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_we,
    input  logic [fhm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fhm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import fhm_pkg::*;

    // Configuration registers.
    logic [SIZE_CFG_W-1:0] r_cfg_width;
    logic [SIZE_CFG_W-1:0] r_cfg_height;
    logic [PIX_W-1:0]      r_cfg_base;
    logic [SEED_W-1:0]     r_cfg_seed;

    // Sequencer registers and their next values.
    t_state            r_state,     n_state;
    logic [ADDR_W-1:0] r_addr,      n_addr;
    logic              r_fill_base, n_fill_base;
    t_in_item          r_cmd,       n_cmd;
    logic [DIM_W-1:0]  r_w,         n_w;
    logic [DIM_W-1:0]  r_h,         n_h;
    logic [SIZE_W-1:0] r_bottom,    n_bottom;
    logic [DIM_W-1:0]  r_col,       n_col;
    logic [DIM_W-1:0]  r_row,       n_row;
    logic [ADDR_W-1:0] r_pos,       n_pos;
    logic [SEED_W-1:0] r_lfsr,      n_lfsr;
    logic [PIX_W-1:0]  r_result,    n_result;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,       n_out;

    // RAM interface.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [PIX_W-1:0]  ram_rdata;

    // Working values of the shared address unit.
    logic [DIM_W-1:0]  cl_w;
    logic [DIM_W-1:0]  cl_h;
    logic [SIZE_W-1:0] frame_end;
    logic              in_bottom;
    logic              read_in_frame;
    logic [SEED_W-1:0] lfsr_next;
    logic [1:0]        drift;
    logic [SIZE_W:0]   sp_base;
    logic [SIZE_W:0]   sp_sub;
    logic [SIZE_W-1:0] sp_above;
    logic              in_accept;
    logic              out_free;

    fhm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_heat_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
            r_cfg_base   <= BASE_RESET;
            r_cfg_seed   <= SEED_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data[SIZE_CFG_W-1:0];
                CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data[SIZE_CFG_W-1:0];
                CFG_BASE_INTENS:  r_cfg_base   <= i_cfg_data[PIX_W-1:0];
                CFG_RANDOM_SEED:  r_cfg_seed   <= i_cfg_data[SEED_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared address arithmetic.
    assign cl_w      = clamp_dim(r_cfg_width, MAX_WIDTH);
    assign cl_h      = clamp_dim(r_cfg_height, MAX_HEIGHT);
    assign frame_end = r_bottom + SIZE_W'(r_w);
    assign in_bottom = (SIZE_W'(r_addr) >= r_bottom) && (SIZE_W'(r_addr) < frame_end);
    assign read_in_frame = (32'(r_cmd.read_index) < 32'(frame_end))
                        && (32'(r_cmd.read_index) < STORE_DEPTH);
    assign lfsr_next = lfsr_step(r_lfsr);
    assign drift     = lfsr_next[1:0];
    assign sp_base   = (SIZE_W+1)'(r_pos) + (SIZE_W+1)'(1);
    assign sp_sub    = (SIZE_W+1)'(r_w) + (SIZE_W+1)'(drift);
    assign sp_above  = SIZE_W'(r_pos) - SIZE_W'(r_w);

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    // State register and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_addr      <= '0;
            r_fill_base <= 1'b0;
            r_lfsr      <= SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_fill_base <= n_fill_base;
            r_lfsr      <= n_lfsr;
            r_out_valid <= n_out_valid;
        end
        r_cmd    <= n_cmd;
        r_w      <= n_w;
        r_h      <= n_h;
        r_bottom <= n_bottom;
        r_col    <= n_col;
        r_row    <= n_row;
        r_pos    <= n_pos;
        r_result <= n_result;
        r_out    <= n_out;
    end

    // Next state, RAM control and result handling.
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_fill_base = r_fill_base;
        n_cmd       = r_cmd;
        n_w         = r_w;
        n_h         = r_h;
        n_bottom    = r_bottom;
        n_col       = r_col;
        n_row       = r_row;
        n_pos       = r_pos;
        n_lfsr      = r_lfsr;
        n_result    = r_result;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;
        ram_raddr   = r_pos;

        unique case (r_state)
            // Sweep over the whole store: zero, or the base value in the bottom row.
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = (r_fill_base && in_bottom) ? r_cfg_base : '0;
                n_addr    = r_addr + ADDR_W'(1);
                if (r_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_addr = '0;
                    if (r_fill_base) begin
                        n_lfsr   = (r_cfg_seed == '0) ? SEED_W'(1) : r_cfg_seed;
                        n_result = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_IDLE: begin
                if (in_accept) begin
                    n_cmd   = i_in_item;
                    n_state = S_SETUP;
                end
            end

            // Latch the frame size and branch on the command.
            S_SETUP: begin
                n_w      = cl_w;
                n_h      = cl_h;
                n_bottom = SIZE_W'(cl_h - DIM_W'(1)) * SIZE_W'(cl_w);
                case (r_cmd.kind)
                    KIND_INIT: begin
                        n_addr      = '0;
                        n_fill_base = 1'b1;
                        n_state     = S_SWEEP;
                    end
                    KIND_SPREAD: begin
                        n_col   = '0;
                        n_row   = DIM_W'(1);
                        n_pos   = ADDR_W'(cl_w);
                        n_state = S_SP_READ;
                    end
                    KIND_READ: begin
                        n_state = S_RD_ISSUE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_RD_ISSUE: begin
                ram_raddr = ADDR_W'(r_cmd.read_index);
                if (read_in_frame) begin
                    n_state = S_RD_WAIT;
                end else begin
                    n_result = '0;
                    n_state  = S_DONE;
                end
            end

            S_RD_WAIT: begin
                n_result = ram_rdata;
                n_state  = S_DONE;
            end

            S_SP_READ: begin
                ram_raddr = r_pos;
                n_state   = S_SP_WRITE;
            end

            // Move one pixel upward with drift and decay, then advance to the next pixel.
            S_SP_WRITE: begin
                n_lfsr = lfsr_next;
                if (ram_rdata == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(sp_above);
                    ram_wdata = '0;
                end else if (sp_base >= sp_sub) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(sp_base - sp_sub);
                    ram_wdata = ram_rdata - PIX_W'(drift[0]);
                end
                if (r_row == r_h - DIM_W'(1)) begin
                    if (r_col == r_w - DIM_W'(1)) begin
                        n_result = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_col   = r_col + DIM_W'(1);
                        n_row   = DIM_W'(1);
                        n_pos   = ADDR_W'(r_w) + ADDR_W'(r_col) + ADDR_W'(1);
                        n_state = S_SP_READ;
                    end
                end else begin
                    n_row   = r_row + DIM_W'(1);
                    n_pos   = r_pos + ADDR_W'(r_w);
                    n_state = S_SP_READ;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.pixel_value = r_result;
                    n_out.done_kind   = r_cmd.kind;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    // The noise generator never locks up at zero.
    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("noise register reached zero");

    // A spread write never lands past the pixel being processed.
    a_spread_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SP_WRITE && ram_we) |-> (ram_waddr <= r_pos))
        else $error("spread write beyond current pixel");

    // The spread row counter stays inside rows 1 to height-1.
    a_spread_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SP_WRITE) |-> (r_row != '0 && r_row < r_h))
        else $error("spread row out of range");

    // The sweep address steps by one each cycle of the sweep.
    a_sweep_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && $past(r_state) == S_SWEEP && $past(i_rst_n))
        |-> (r_addr == $past(r_addr) + ADDR_W'(1)))
        else $error("sweep address skipped");

    // A finished request reaches the output on the next edge once the register is free.
    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not delivered");
`endif

endmodule
